// ===== design/load_store_byte_lane_unit_defines.svh =====
// ---------------------------------------------------------------------------
// load_store_byte_lane_unit_defines
// assertion macros shared by the load/store unit
// ---------------------------------------------------------------------------
`ifndef LOAD_STORE_BYTE_LANE_UNIT_DEFINES_SVH
`define LOAD_STORE_BYTE_LANE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSBL_CHECK(label, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSBL_CHECK_NEXT(label, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

// ===== design/lsbl_pkg.sv =====
// ---------------------------------------------------------------------------
// lsbl_pkg
// types and constants of the load/store unit
// ---------------------------------------------------------------------------
package lsbl_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_LW  = 3'd0;
    localparam kind_t KIND_LH  = 3'd1;
    localparam kind_t KIND_LHU = 3'd2;
    localparam kind_t KIND_LB  = 3'd3;
    localparam kind_t KIND_LBU = 3'd4;
    localparam kind_t KIND_SW  = 3'd5;
    localparam kind_t KIND_SH  = 3'd6;
    localparam kind_t KIND_SB  = 3'd7;

    localparam logic [31:0] KEEP_HI_HALF = 32'hFFFF_0000;
    localparam logic [31:0] KEEP_LO_HALF = 32'h0000_FFFF;
    localparam logic [31:0] KEEP_NOT_B0  = 32'hFFFF_FF00;
    localparam logic [31:0] KEEP_NOT_B1  = 32'hFFFF_00FF;
    localparam logic [31:0] KEEP_NOT_B2  = 32'hFF00_FFFF;
    localparam logic [31:0] KEEP_NOT_B3  = 32'h00FF_FFFF;

    typedef struct packed {
        logic               misaligned;
        logic signed [31:0] load_value;
        logic               wr_en;
        logic [31:0]        wr_data;
    } lane_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wrap_stat_t;

endpackage

// ===== design/lsbl_if.sv =====
// ---------------------------------------------------------------------------
// lsbl_if
// request and response channels of the load/store unit
// ---------------------------------------------------------------------------
interface lsbl_req_if;
    import lsbl_pkg::*;

    logic               valid;
    logic               ready;
    kind_t              kind;
    logic [31:0]        base_address;
    logic signed [11:0] offset;
    logic [31:0]        store_value;

    modport source (output valid, kind, base_address, offset, store_value, input ready);
    modport sink (input valid, kind, base_address, offset, store_value, output ready);
endinterface

interface lsbl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] load_value;
    logic               misaligned;

    modport source (output valid, load_value, misaligned, input ready);
    modport sink (input valid, load_value, misaligned, output ready);
endinterface

// ===== design/lsbl_ram.sv =====
// ---------------------------------------------------------------------------
// lsbl_ram
// word memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module lsbl_ram #(
    parameter int WORDS = 1024,
    parameter int IDX_W = $clog2(WORDS)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [31:0]      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_data
);

    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lsbl_wrap.sv =====
// ---------------------------------------------------------------------------
// lsbl_wrap
// word index modulo the memory depth, reciprocal multiply and one correction
// ---------------------------------------------------------------------------
module lsbl_wrap #(
    parameter int WORDS = 1024,
    parameter int IDX_W = $clog2(WORDS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [29:0]          addr_words,
    output lsbl_pkg::wrap_stat_t stat,
    output logic [IDX_W-1:0]     idx
);
    import lsbl_pkg::*;

    localparam bit          IS_POW2  = (WORDS & (WORDS - 1)) == 0;
    localparam int          RECIP_SH = 30 + IDX_W;
    localparam int          Q_W      = 31 - IDX_W;
    localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / 64'(WORDS);
    localparam logic [30:0] RECIP_M  = RECIP[30:0];
    localparam logic [29:0] MOD_BASE = 30'(WORDS);

    localparam logic [1:0] STEP_QUOT = 2'd0;
    localparam logic [1:0] STEP_SUB  = 2'd1;
    localparam logic [1:0] STEP_FIX  = 2'd2;

    logic [29:0]    rem_reg, rem_next;
    logic [Q_W-1:0] q_reg, q_next;
    logic [1:0]     step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [60:0]    prod;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        prod      = {31'd0, rem_reg} * {30'd0, RECIP_M};
        if (start)
        begin
            rem_next  = addr_words;
            step_next = STEP_QUOT;
            busy_next = !IS_POW2;
            done_next = IS_POW2;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                STEP_QUOT:
                begin
                    // quotient estimate, low by at most one
                    q_next    = Q_W'(prod >> RECIP_SH);
                    step_next = STEP_SUB;
                end
                STEP_SUB:
                begin
                    rem_next  = rem_reg - ({{(IDX_W - 1){1'b0}}, q_reg} * MOD_BASE);
                    step_next = STEP_FIX;
                end
                STEP_FIX:
                begin
                    if (rem_reg >= MOD_BASE)
                    begin
                        rem_next = rem_reg - MOD_BASE;
                    end
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_QUOT;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign idx       = rem_reg[IDX_W-1:0];

endmodule

// ===== design/lsbl_lane.sv =====
// ---------------------------------------------------------------------------
// lsbl_lane
// lane select and extend for loads, lane merge for stores, alignment check
// ---------------------------------------------------------------------------
module lsbl_lane (
    input  lsbl_pkg::kind_t     kind,
    input  logic [1:0]          addr_lo,
    input  logic [31:0]         word,
    input  logic [31:0]         store_value,
    output lsbl_pkg::lane_res_t res
);
    import lsbl_pkg::*;

    logic [4:0]  shift;
    logic [15:0] half;
    logic [7:0]  byte_sel;
    logic [31:0] keep;
    logic [31:0] merged;

    always_comb
    begin
        shift = {addr_lo, 3'b000};
        half  = addr_lo[1] ? word[31:16] : word[15:0];
        case (addr_lo)
            2'd0:    byte_sel = word[7:0];
            2'd1:    byte_sel = word[15:8];
            2'd2:    byte_sel = word[23:16];
            default: byte_sel = word[31:24];
        endcase
        if (kind == KIND_SH)
        begin
            keep = addr_lo[1] ? KEEP_LO_HALF : KEEP_HI_HALF;
        end
        else
        begin
            case (addr_lo)
                2'd0:    keep = KEEP_NOT_B0;
                2'd1:    keep = KEEP_NOT_B1;
                2'd2:    keep = KEEP_NOT_B2;
                default: keep = KEEP_NOT_B3;
            endcase
        end
        merged = (word & keep) | ((store_value << shift) & ~keep);

        res.misaligned = 1'b0;
        res.load_value = '0;
        res.wr_en      = 1'b0;
        res.wr_data    = merged;
        unique case (kind) inside
            KIND_LW:
            begin
                res.misaligned = addr_lo != 2'd0;
                if (addr_lo == 2'd0)
                begin
                    res.load_value = word;
                end
            end
            KIND_LH, KIND_LHU:
            begin
                res.misaligned = addr_lo[0];
                if (!addr_lo[0])
                begin
                    res.load_value = {{16{half[15] && (kind == KIND_LH)}}, half};
                end
            end
            KIND_LB, KIND_LBU:
            begin
                res.load_value = {{24{byte_sel[7] && (kind == KIND_LB)}}, byte_sel};
            end
            KIND_SW:
            begin
                res.misaligned = addr_lo != 2'd0;
                res.wr_en      = addr_lo == 2'd0;
                res.wr_data    = store_value;
            end
            KIND_SH:
            begin
                res.misaligned = addr_lo[0];
                res.wr_en      = !addr_lo[0];
            end
            KIND_SB:
            begin
                res.wr_en = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/load_store_byte_lane_unit.sv =====
// ---------------------------------------------------------------------------
// load_store_byte_lane_unit
// rv32i style load/store unit over a little-endian word memory
//
// channel  dir  handshake     payload
// req      in   valid/ready   kind, base_address, offset, store_value
// rsp      out  valid/ready   load_value, misaligned
//
// one request at a time: accept, index wrap, memory read, lane merge/write
// the index wrap runs no steps when MEM_WORDS is a power of two
// otherwise it adds quotient estimate, subtract and correction for the reciprocal modulo
// result sits in an output register; a stalled rsp holds the merge state
// async reset clears control only; memory contents undefined until written
// ---------------------------------------------------------------------------
`include "load_store_byte_lane_unit_defines.svh"

module load_store_byte_lane_unit #(
    parameter int MEM_WORDS = 1024
) (
    input logic       clk,
    input logic       rst_n,
    lsbl_req_if.sink  req,
    lsbl_rsp_if.source rsp
);
    import lsbl_pkg::*;

    localparam int IDX_W = $clog2(MEM_WORDS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WRAP = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;

    logic [1:0]         state_reg, state_next;
    kind_t              kind_reg;
    logic [1:0]         addr_lo_reg;
    logic [31:0]        store_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_load_reg;
    logic               out_mis_reg;

    logic [31:0]      eff_addr;
    logic             accept;
    logic             can_out;
    logic             ram_rd_en;
    logic             ram_wr_en;
    logic [31:0]      ram_rd_data;
    logic [IDX_W-1:0] idx;
    wrap_stat_t       wrap_stat;
    lane_res_t        lane_res;

    assign eff_addr  = req.base_address + {{20{req.offset[11]}}, req.offset};
    assign req.ready = state_reg == ST_IDLE;
    assign accept    = req.valid && req.ready;
    assign can_out   = !out_valid_reg || rsp.ready;
    assign ram_rd_en = (state_reg == ST_WRAP) && wrap_stat.done;
    assign ram_wr_en = (state_reg == ST_MOD) && can_out && lane_res.wr_en;

    lsbl_wrap #(
        .WORDS (MEM_WORDS),
        .IDX_W (IDX_W)
    ) u_wrap (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .addr_words (eff_addr[31:2]),
        .stat       (wrap_stat),
        .idx        (idx)
    );

    lsbl_ram #(
        .WORDS (MEM_WORDS),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_idx  (idx),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_idx  (idx),
        .wr_data (lane_res.wr_data)
    );

    lsbl_lane u_lane (
        .kind        (kind_reg),
        .addr_lo     (addr_lo_reg),
        .word        (ram_rd_data),
        .store_value (store_reg),
        .res         (lane_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (wrap_stat.done)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (can_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_MOD) && can_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req.kind;
            addr_lo_reg <= eff_addr[1:0];
            store_reg   <= req.store_value;
        end
        if ((state_reg == ST_MOD) && can_out)
        begin
            out_load_reg <= lane_res.load_value;
            out_mis_reg  <= lane_res.misaligned;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.load_value = out_load_reg;
    assign rsp.misaligned = out_mis_reg;

    `LSBL_CHECK(a_write_in_merge, ram_wr_en, state_reg == ST_MOD, "memory write outside merge")
    `LSBL_CHECK(a_rsp_from_merge, $rose(out_valid_reg), $past(state_reg == ST_MOD),
        "response raised without merge")
    `LSBL_CHECK(a_mis_zero, out_valid_reg && out_mis_reg, out_load_reg == 32'sd0,
        "misaligned response with nonzero data")
    `LSBL_CHECK(a_idx_range, ram_rd_en, 32'(idx) < 32'(MEM_WORDS), "word index beyond depth")
    `LSBL_CHECK_NEXT(a_accept_wrap, accept, state_reg == ST_WRAP, "accepted request not in wrap")
    `LSBL_CHECK(a_wrap_idle, state_reg == ST_IDLE, !wrap_stat.busy, "index wrap busy while idle")

endmodule
